### sv/owtr_pkg.sv
// Shared types and constants of the 1-Wire master and temperature reader.
package owtr_pkg;

	// Command codes carried with each tick.
	localparam logic [2:0] CMD_NONE  = 3'd0;
	localparam logic [2:0] CMD_RESET = 3'd1;
	localparam logic [2:0] CMD_WRITE = 3'd2;
	localparam logic [2:0] CMD_READ  = 3'd3;
	localparam logic [2:0] CMD_TEMP  = 3'd4;

	// Configuration register indexes.
	localparam logic [2:0] REG_RST_LOW   = 3'd0;
	localparam logic [2:0] REG_RST_REL   = 3'd1;
	localparam logic [2:0] REG_PRES_WAIT = 3'd2;
	localparam logic [2:0] REG_RD_LOW    = 3'd3;
	localparam logic [2:0] REG_RD_SAMPLE = 3'd4;
	localparam logic [2:0] REG_RD_REC    = 3'd5;
	localparam logic [2:0] REG_WR_SHORT  = 3'd6;
	localparam logic [2:0] REG_WR_LONG   = 3'd7;

	// Register reset values.
	localparam logic [15:0] RST_LOW_INIT   = 16'd17120;
	localparam logic [15:0] RST_REL_INIT   = 16'd1600;
	localparam logic [15:0] PRES_WAIT_INIT = 16'd5600;
	localparam logic [15:0] RD_LOW_INIT    = 16'd134;
	localparam logic [15:0] RD_SAMPLE_INIT = 16'd134;
	localparam logic [15:0] RD_REC_INIT    = 16'd1200;
	localparam logic [15:0] WR_SHORT_INIT  = 16'd30;
	localparam logic [15:0] WR_LONG_INIT   = 16'd2400;

	// Fixed phase lengths.
	localparam logic [15:0] PRE_RESET_HIGH_TICKS = 16'd367;
	localparam logic [15:0] POST_RESET_GAP_TICKS = 16'd300;

	// Temperature program steps.
	localparam logic [3:0] STEP_NONE  = 4'd0;
	localparam logic [3:0] STEP_RST1  = 4'd1;
	localparam logic [3:0] STEP_GAP   = 4'd2;
	localparam logic [3:0] STEP_SKIP1 = 4'd3;
	localparam logic [3:0] STEP_CONV  = 4'd4;
	localparam logic [3:0] STEP_RST2  = 4'd5;
	localparam logic [3:0] STEP_SKIP2 = 4'd6;
	localparam logic [3:0] STEP_RDSP  = 4'd7;
	localparam logic [3:0] STEP_RD_LO = 4'd8;
	localparam logic [3:0] STEP_RD_HI = 4'd9;

	// ROM commands of the sensor.
	localparam logic [7:0] ROM_SKIP      = 8'hCC;
	localparam logic [7:0] FN_CONVERT    = 8'h44;
	localparam logic [7:0] FN_READ_SCRPD = 8'hBE;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	// Timing registers as seen by the engine.
	typedef struct packed {
		logic [15:0] rst_low;
		logic [15:0] rst_rel;
		logic [15:0] pres_wait;
		logic [15:0] rd_low;
		logic [15:0] rd_sample;
		logic [15:0] rd_rec;
		logic [15:0] wr_short;
		logic [15:0] wr_long;
	} cfg_t;

	// Result of one tick.
	typedef struct packed {
		logic        presence_level;
		logic [15:0] temperature_raw;
		logic [7:0]  read_data;
		logic        done_res;
		logic        busy_res;
		logic        pin_level;
		logic        pin_drive;
	} res_t;

endpackage

### sv/owtr_cfg_regs.sv
// Timing configuration registers of the 1-Wire master.
module owtr_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [2:0]        wr_index,
	input  logic [15:0]       wr_data,
	output owtr_pkg::cfg_t    cfg
);

	owtr_pkg::cfg_t cfg_q;

	// Register file with reset defaults; one register per request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rst_low   <= owtr_pkg::RST_LOW_INIT;
			cfg_q.rst_rel   <= owtr_pkg::RST_REL_INIT;
			cfg_q.pres_wait <= owtr_pkg::PRES_WAIT_INIT;
			cfg_q.rd_low    <= owtr_pkg::RD_LOW_INIT;
			cfg_q.rd_sample <= owtr_pkg::RD_SAMPLE_INIT;
			cfg_q.rd_rec    <= owtr_pkg::RD_REC_INIT;
			cfg_q.wr_short  <= owtr_pkg::WR_SHORT_INIT;
			cfg_q.wr_long   <= owtr_pkg::WR_LONG_INIT;
		end else if (wr_en) begin
			unique case (wr_index)
				owtr_pkg::REG_RST_LOW:   cfg_q.rst_low   <= wr_data;
				owtr_pkg::REG_RST_REL:   cfg_q.rst_rel   <= wr_data;
				owtr_pkg::REG_PRES_WAIT: cfg_q.pres_wait <= wr_data;
				owtr_pkg::REG_RD_LOW:    cfg_q.rd_low    <= wr_data;
				owtr_pkg::REG_RD_SAMPLE: cfg_q.rd_sample <= wr_data;
				owtr_pkg::REG_RD_REC:    cfg_q.rd_rec    <= wr_data;
				owtr_pkg::REG_WR_SHORT:  cfg_q.wr_short  <= wr_data;
				owtr_pkg::REG_WR_LONG:   cfg_q.wr_long   <= wr_data;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### sv/owtr_engine.sv
// Bus timing engine: slot phases, bit shifting and the temperature program.
module owtr_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  logic [2:0]        cmd,
	input  logic [7:0]        data_byte,
	input  logic              line_in,
	input  owtr_pkg::cfg_t    cfg,
	output owtr_pkg::res_t    res
);

	typedef enum logic [12:0] {
		PH_IDLE       = 13'b0_0000_0000_0001,
		PH_RST_PRE    = 13'b0_0000_0000_0010,
		PH_RST_LOW    = 13'b0_0000_0000_0100,
		PH_RST_REL    = 13'b0_0000_0000_1000,
		PH_RST_WAIT   = 13'b0_0000_0001_0000,
		PH_RST_SAMPLE = 13'b0_0000_0010_0000,
		PH_GAP        = 13'b0_0000_0100_0000,
		PH_WR_FIRST   = 13'b0_0000_1000_0000,
		PH_WR_SECOND  = 13'b0_0001_0000_0000,
		PH_RD_LOW     = 13'b0_0010_0000_0000,
		PH_RD_HIGH    = 13'b0_0100_0000_0000,
		PH_RD_SAMPLE  = 13'b0_1000_0000_0000,
		PH_RD_REC     = 13'b1_0000_0000_0000
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [15:0] tick_q, tick_d;
	logic [3:0]  bit_q, bit_d;
	logic [7:0]  shift_q, shift_d;
	logic [3:0]  step_q, step_d;
	logic [15:0] temp_q, temp_d;
	logic        pres_q, pres_d;
	logic [7:0]  rcv_q, rcv_d;

	logic        drive, level, done, finish, was_read;
	logic [15:0] len;

	// One tick of the bus master: start, drive, sample, count and advance.
	always_comb begin
		phase_d  = phase_q;
		tick_d   = tick_q;
		bit_d    = bit_q;
		shift_d  = shift_q;
		step_d   = step_q;
		temp_d   = temp_q;
		pres_d   = pres_q;
		rcv_d    = rcv_q;
		drive    = 1'b1;
		level    = 1'b1;
		done     = 1'b0;
		finish   = 1'b0;
		was_read = 1'b0;
		len      = 16'd1;

		// A command is taken only while idle; unknown codes are ignored.
		if (phase_q == PH_IDLE) begin
			case (cmd)
				owtr_pkg::CMD_RESET: begin
					step_d  = owtr_pkg::STEP_NONE;
					phase_d = PH_RST_PRE;
					tick_d  = 16'd0;
				end
				owtr_pkg::CMD_WRITE: begin
					step_d  = owtr_pkg::STEP_NONE;
					shift_d = data_byte;
					bit_d   = 4'd0;
					phase_d = PH_WR_FIRST;
					tick_d  = 16'd0;
				end
				owtr_pkg::CMD_READ: begin
					step_d  = owtr_pkg::STEP_NONE;
					shift_d = 8'd0;
					bit_d   = 4'd0;
					phase_d = PH_RD_LOW;
					tick_d  = 16'd0;
				end
				owtr_pkg::CMD_TEMP: begin
					step_d  = owtr_pkg::STEP_RST1;
					phase_d = PH_RST_PRE;
					tick_d  = 16'd0;
				end
				default: ;
			endcase
		end

		if (phase_d != PH_IDLE) begin
			// Pin control and sampling for the current phase.
			unique case (phase_d)
				PH_RST_LOW, PH_WR_FIRST, PH_RD_LOW: level = 1'b0;
				PH_RST_WAIT: begin
					drive = 1'b0;
					level = 1'b0;
				end
				PH_RST_SAMPLE: begin
					drive  = 1'b0;
					level  = 1'b0;
					pres_d = line_in;
				end
				PH_RD_SAMPLE: begin
					drive   = 1'b0;
					level   = 1'b0;
					shift_d = {line_in, shift_d[7:1]};
				end
				default: ;
			endcase

			// Phase length; a zero length still lasts one tick since the count is at least one.
			unique case (phase_d)
				PH_RST_PRE:   len = owtr_pkg::PRE_RESET_HIGH_TICKS;
				PH_RST_LOW:   len = cfg.rst_low;
				PH_RST_REL:   len = cfg.rst_rel;
				PH_RST_WAIT:  len = cfg.pres_wait;
				PH_GAP:       len = owtr_pkg::POST_RESET_GAP_TICKS;
				PH_WR_FIRST:  len = shift_d[0] ? cfg.wr_short : cfg.wr_long;
				PH_WR_SECOND: len = shift_d[0] ? cfg.wr_long : cfg.wr_short;
				PH_RD_LOW:    len = cfg.rd_low;
				PH_RD_HIGH:   len = cfg.rd_sample;
				PH_RD_REC:    len = cfg.rd_rec;
				default:      len = 16'd1;
			endcase

			tick_d = 16'(tick_d + 16'd1);
			if (tick_d >= len) begin
				tick_d = 16'd0;
				unique case (phase_d)
					PH_RST_PRE:    phase_d = PH_RST_LOW;
					PH_RST_LOW:    phase_d = PH_RST_REL;
					PH_RST_REL:    phase_d = PH_RST_WAIT;
					PH_RST_WAIT:   phase_d = PH_RST_SAMPLE;
					PH_RST_SAMPLE: finish  = 1'b1;
					PH_GAP:        finish  = 1'b1;
					PH_WR_FIRST:   phase_d = PH_WR_SECOND;
					PH_WR_SECOND: begin
						shift_d = {1'b0, shift_d[7:1]};
						bit_d   = 4'(bit_d + 4'd1);
						if (bit_d >= owtr_pkg::BITS_PER_BYTE) begin
							finish = 1'b1;
						end else begin
							phase_d = PH_WR_FIRST;
						end
					end
					PH_RD_LOW:    phase_d = PH_RD_HIGH;
					PH_RD_HIGH:   phase_d = PH_RD_SAMPLE;
					PH_RD_SAMPLE: phase_d = PH_RD_REC;
					PH_RD_REC: begin
						bit_d = 4'(bit_d + 4'd1);
						if (bit_d >= owtr_pkg::BITS_PER_BYTE) begin
							finish   = 1'b1;
							was_read = 1'b1;
						end else begin
							phase_d = PH_RD_LOW;
						end
					end
					default: phase_d = PH_IDLE;
				endcase
			end

			// End of an operation: store read bytes, then finish or start the next step.
			if (finish) begin
				if (was_read) begin
					if (step_d == owtr_pkg::STEP_RD_HI) begin
						temp_d = {shift_d, rcv_d};
					end
					rcv_d = shift_d;
				end
				if (step_d == owtr_pkg::STEP_NONE) begin
					phase_d = PH_IDLE;
					done    = 1'b1;
				end else begin
					step_d = 4'(step_d + 4'd1);
					if (step_d == owtr_pkg::STEP_GAP &&
						owtr_pkg::POST_RESET_GAP_TICKS == 16'd0) begin
						step_d = owtr_pkg::STEP_SKIP1;
					end
					case (step_d)
						owtr_pkg::STEP_RST1, owtr_pkg::STEP_RST2: phase_d = PH_RST_PRE;
						owtr_pkg::STEP_GAP: phase_d = PH_GAP;
						owtr_pkg::STEP_SKIP1, owtr_pkg::STEP_SKIP2: begin
							shift_d = owtr_pkg::ROM_SKIP;
							bit_d   = 4'd0;
							phase_d = PH_WR_FIRST;
						end
						owtr_pkg::STEP_CONV: begin
							shift_d = owtr_pkg::FN_CONVERT;
							bit_d   = 4'd0;
							phase_d = PH_WR_FIRST;
						end
						owtr_pkg::STEP_RDSP: begin
							shift_d = owtr_pkg::FN_READ_SCRPD;
							bit_d   = 4'd0;
							phase_d = PH_WR_FIRST;
						end
						owtr_pkg::STEP_RD_LO, owtr_pkg::STEP_RD_HI: begin
							shift_d = 8'd0;
							bit_d   = 4'd0;
							phase_d = PH_RD_LOW;
						end
						default: begin
							step_d  = owtr_pkg::STEP_NONE;
							phase_d = PH_IDLE;
							done    = 1'b1;
						end
					endcase
				end
			end
		end

		res.pin_drive       = drive;
		res.pin_level       = level;
		res.busy_res        = (phase_d != PH_IDLE);
		res.done_res        = done;
		res.read_data       = rcv_d;
		res.temperature_raw = temp_d;
		res.presence_level  = pres_d;
	end

	// Engine state advances once per tick taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= 16'd0;
			bit_q   <= 4'd0;
			shift_q <= 8'd0;
			step_q  <= owtr_pkg::STEP_NONE;
			temp_q  <= 16'd0;
			pres_q  <= 1'b1;
			rcv_q   <= 8'd0;
		end else if (step_en) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			step_q  <= step_d;
			temp_q  <= temp_d;
			pres_q  <= pres_d;
			rcv_q   <= rcv_d;
		end
	end

	// The program step is cleared whenever the engine rests.
	a_idle_no_step: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> step_q == owtr_pkg::STEP_NONE)
		else $error("program step left over while idle");

	// A bit counter never runs past one byte.
	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q <= owtr_pkg::BITS_PER_BYTE)
		else $error("bit counter out of range");

	// A finishing tick never reports the engine still busy.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && res.done_res |-> !res.busy_res)
		else $error("done and busy together");

	// The temperature word changes only at the end of the high byte read.
	a_temp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(step_en && phase_q == PH_RD_REC && step_q == owtr_pkg::STEP_RD_HI)
		|=> $stable(temp_q))
		else $error("temperature word changed outside the final read");

endmodule

### sv/one_wire_master_temp_reader_core.sv
// Top level of the 1-Wire bus master with temperature read program.
//
// Each request on the s_axis channel is one timing tick: it carries the sampled
// bus level and an optional command. Every tick yields exactly one result on
// m_axis with the pin control, busy and done flags, the last received byte,
// the last temperature word and the last presence sample.
// A tick request lands in an input register; the timing engine evaluates it in
// one pass as it moves on, and the result is written to the output register.
// One tick is taken per cycle while the receiver keeps m_axis_tready high.
// When the receiver stalls, the output register holds its result, the input
// register holds one more tick, and s_axis_tready drops until space frees up.
// The cfg channel writes one of the eight timing registers per request and is
// always ready; writes must be made while no command runs; the block does not enforce it.
// After reset the engine is idle with the pin driven high, the presence level
// reads one, the engine's data outputs read zero and the timing registers hold their
// default values.
module one_wire_master_temp_reader_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // command[2:0], data_byte[10:3], line_in[11], zero fill
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // pin_drive[0], pin_level[1], busy_res[2], done_res[3],
	                                    // read_data[11:4], temperature_raw[27:12],
	                                    // presence_level[28], zero fill
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic           valid_s1;
	logic [2:0]     cmd_s1;
	logic [7:0]     byte_s1;
	logic           line_s1;
	logic           valid_s2;
	owtr_pkg::res_t res_s2;
	owtr_pkg::res_t res;
	owtr_pkg::cfg_t cfg;
	logic           adv_s1;
	logic           take_in;

	assign cfg_ready     = 1'b1;
	assign adv_s1        = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign take_in       = s_axis_tvalid && s_axis_tready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			cmd_s1  <= s_axis_tdata[2:0];
			byte_s1 <= s_axis_tdata[10:3];
			line_s1 <= s_axis_tdata[11];
		end
	end

	owtr_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	owtr_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (adv_s1),
		.cmd       (cmd_s1),
		.data_byte (byte_s1),
		.line_in   (line_s1),
		.cfg       (cfg),
		.res       (res)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {3'b000, res_s2};

endmodule

### tb/owtr_result_checker.sv
// Result checker for the 1-Wire master: predicts every tick result and compares it on m_axis.
module owtr_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // command[2:0], data_byte[10:3], line_in[11], zero fill
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,   // pin_drive[0], pin_level[1], busy_res[2], done_res[3],
	                                    // read_data[11:4], temperature_raw[27:12],
	                                    // presence_level[28], zero fill
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int unsigned fail_count,
	output int unsigned outstanding
);
	import owtr_pkg::*;

	// Bus slot the predicted master is in.
	typedef enum logic [3:0] {
		S_IDLE,
		S_RST_HIGH,
		S_RST_LOW,
		S_RST_RELEASE,
		S_PRES_WAIT,
		S_PRES_SAMPLE,
		S_GAP,
		S_WR_A,
		S_WR_B,
		S_RD_LOW,
		S_RD_HIGH,
		S_RD_SAMPLE,
		S_RD_RECOVER
	} slot_e;

	// Predicted master state and timing registers.
	slot_e       slot;
	logic [15:0] slot_ticks;
	logic [3:0]  bit_idx;
	logic [7:0]  shifter;
	logic [3:0]  step;
	logic [15:0] temp_word;
	logic        presence;
	logic [7:0]  rx_byte;
	logic        finished;
	logic [15:0] timing [8];

	// Results predicted for ticks whose result has not been taken yet.
	res_t expected_ticks[$];

	task automatic enter_slot(input slot_e s);
		slot = s;
		slot_ticks = 16'd0;
	endtask

	task automatic load_write(input logic [7:0] b);
		shifter = b;
		bit_idx = 4'd0;
		enter_slot(S_WR_A);
	endtask

	task automatic load_read();
		shifter = 8'd0;
		bit_idx = 4'd0;
		enter_slot(S_RD_LOW);
	endtask

	// Starts one step of the temperature program; past the last step the program ends.
	task automatic run_step(input logic [3:0] n);
		step = n;
		case (n)
			STEP_RST1, STEP_RST2: enter_slot(S_RST_HIGH);
			STEP_GAP: begin
				if (POST_RESET_GAP_TICKS == 16'd0) begin
					step = STEP_SKIP1;
					load_write(ROM_SKIP);
				end else begin
					enter_slot(S_GAP);
				end
			end
			STEP_SKIP1, STEP_SKIP2: load_write(ROM_SKIP);
			STEP_CONV: load_write(FN_CONVERT);
			STEP_RDSP: load_write(FN_READ_SCRPD);
			STEP_RD_LO, STEP_RD_HI: load_read();
			default: begin
				step = STEP_NONE;
				enter_slot(S_IDLE);
				finished = 1'b1;
			end
		endcase
	endtask

	// End of a reset, gap or byte: a single command finishes, a program moves on.
	task automatic close_op(input logic was_read);
		if (was_read) begin
			if (step == STEP_RD_HI)
				temp_word = {shifter, rx_byte};
			rx_byte = shifter;
		end
		if (step == STEP_NONE) begin
			enter_slot(S_IDLE);
			finished = 1'b1;
		end else begin
			run_step(step + 4'd1);
		end
	endtask

	// One tick of the master: pin control, sampling and phase timing.
	task automatic predict_tick(input logic [2:0] cmd, input logic [7:0] data, input logic line,
			output res_t r);
		logic        drive;
		logic        level;
		logic [15:0] len;
		drive = 1'b1;
		level = 1'b1;
		finished = 1'b0;

		// A command is taken only while idle; anything else is ignored.
		if (slot == S_IDLE) begin
			case (cmd)
				CMD_RESET: begin
					step = STEP_NONE;
					enter_slot(S_RST_HIGH);
				end
				CMD_WRITE: begin
					step = STEP_NONE;
					load_write(data);
				end
				CMD_READ: begin
					step = STEP_NONE;
					load_read();
				end
				CMD_TEMP: run_step(STEP_RST1);
				default: ;
			endcase
		end

		if (slot != S_IDLE) begin
			case (slot)
				S_RST_LOW, S_WR_A, S_RD_LOW: level = 1'b0;
				S_PRES_WAIT: begin
					drive = 1'b0;
					level = 1'b0;
				end
				S_PRES_SAMPLE: begin
					drive = 1'b0;
					level = 1'b0;
					presence = line;
				end
				S_RD_SAMPLE: begin
					drive = 1'b0;
					level = 1'b0;
					shifter = {line, shifter[7:1]};
				end
				default: ;
			endcase

			// Length of the current phase; a zero length still takes one tick.
			case (slot)
				S_RST_HIGH:    len = PRE_RESET_HIGH_TICKS;
				S_RST_LOW:     len = timing[REG_RST_LOW];
				S_RST_RELEASE: len = timing[REG_RST_REL];
				S_PRES_WAIT:   len = timing[REG_PRES_WAIT];
				S_GAP:         len = POST_RESET_GAP_TICKS;
				S_WR_A:        len = shifter[0] ? timing[REG_WR_SHORT] : timing[REG_WR_LONG];
				S_WR_B:        len = shifter[0] ? timing[REG_WR_LONG] : timing[REG_WR_SHORT];
				S_RD_LOW:      len = timing[REG_RD_LOW];
				S_RD_HIGH:     len = timing[REG_RD_SAMPLE];
				S_RD_RECOVER:  len = timing[REG_RD_REC];
				default:       len = 16'd1;
			endcase
			if (len == 16'd0)
				len = 16'd1;

			slot_ticks = slot_ticks + 16'd1;
			if (slot_ticks >= len) begin
				case (slot)
					S_RST_HIGH:    enter_slot(S_RST_LOW);
					S_RST_LOW:     enter_slot(S_RST_RELEASE);
					S_RST_RELEASE: enter_slot(S_PRES_WAIT);
					S_PRES_WAIT:   enter_slot(S_PRES_SAMPLE);
					S_PRES_SAMPLE, S_GAP: close_op(1'b0);
					S_WR_A:        enter_slot(S_WR_B);
					S_WR_B: begin
						shifter = shifter >> 1;
						bit_idx = bit_idx + 4'd1;
						if (bit_idx >= BITS_PER_BYTE)
							close_op(1'b0);
						else
							enter_slot(S_WR_A);
					end
					S_RD_LOW:      enter_slot(S_RD_HIGH);
					S_RD_HIGH:     enter_slot(S_RD_SAMPLE);
					S_RD_SAMPLE:   enter_slot(S_RD_RECOVER);
					S_RD_RECOVER: begin
						bit_idx = bit_idx + 4'd1;
						if (bit_idx >= BITS_PER_BYTE)
							close_op(1'b1);
						else
							enter_slot(S_RD_LOW);
					end
					default:       enter_slot(S_IDLE);
				endcase
			end
		end

		r.pin_drive = drive;
		r.pin_level = level;
		r.busy_res = (slot != S_IDLE);
		r.done_res = finished;
		r.read_data = rx_byte;
		r.temperature_raw = temp_word;
		r.presence_level = presence;
	endtask

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	// Results are compared before the new tick is predicted, so a result can never
	// match the tick taken at the same edge.
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		res_t got;
		if (!arst_n) begin
			slot = S_IDLE;
			slot_ticks = 16'd0;
			bit_idx = 4'd0;
			shifter = 8'd0;
			step = STEP_NONE;
			temp_word = 16'd0;
			presence = 1'b1;
			rx_byte = 8'd0;
			finished = 1'b0;
			timing[REG_RST_LOW] = RST_LOW_INIT;
			timing[REG_RST_REL] = RST_REL_INIT;
			timing[REG_PRES_WAIT] = PRES_WAIT_INIT;
			timing[REG_RD_LOW] = RD_LOW_INIT;
			timing[REG_RD_SAMPLE] = RD_SAMPLE_INIT;
			timing[REG_RD_REC] = RD_REC_INIT;
			timing[REG_WR_SHORT] = WR_SHORT_INIT;
			timing[REG_WR_LONG] = WR_LONG_INIT;
			expected_ticks.delete();
			fail_count = 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				timing[cfg_index] = cfg_data;

			if (m_axis_tvalid && m_axis_tready) begin
				got = res_t'(m_axis_tdata[$bits(res_t)-1:0]);
				if (expected_ticks.size() == 0) begin
					$error("result with no tick waiting: tdata %h", m_axis_tdata);
					fail_count++;
				end else begin
					want = expected_ticks.pop_front();
					check_field("pin_drive", want.pin_drive, got.pin_drive);
					check_field("pin_level", want.pin_level, got.pin_level);
					check_field("busy_res", want.busy_res, got.busy_res);
					check_field("done_res", want.done_res, got.done_res);
					check_field("read_data", want.read_data, got.read_data);
					check_field("temperature_raw", want.temperature_raw, got.temperature_raw);
					check_field("presence_level", want.presence_level, got.presence_level);
					check_field("tdata fill", 16'd0, m_axis_tdata[31:$bits(res_t)]);
				end
			end

			if (s_axis_tvalid && s_axis_tready) begin
				predict_tick(s_axis_tdata[2:0], s_axis_tdata[10:3], s_axis_tdata[11], want);
				expected_ticks.push_back(want);
			end

			outstanding <= expected_ticks.size();
		end
	end

endmodule

### tb/tb_top.sv
// Top of the 1-Wire master testbench: clock, reset, tick and timing requests, and the verdict.
module tb_top;
	import owtr_pkg::*;

	// Command codes the master does not know.
	localparam logic [2:0] CMD_SPARE_LO = CMD_TEMP + 3'd1;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;
	// Every command runs at least this many ticks after its start, so other
	// commands sent within this window always land on a busy master.
	localparam int unsigned BUSY_SAFE_TICKS = 12;
	// Extra cycles after the last result.
	localparam int unsigned TAIL_CYCLES = 20;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = 16'd0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = REG_RST_LOW;
	logic [15:0] cfg_data = 16'd0;

	int unsigned fail_count;
	int unsigned outstanding;
	int unsigned done_count = 0;
	bit          sender_gaps = 1'b1;
	res_t        out_word;

	one_wire_master_temp_reader_core dut (.*);

	owtr_result_checker u_check (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Count finished commands as their results are taken.
	assign out_word = res_t'(m_axis_tdata[$bits(res_t)-1:0]);
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready && out_word.done_res)
			done_count <= done_count + 1;
	end

	function automatic int unsigned gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
	endfunction

	function automatic logic [2:0] idle_code();
		return ($urandom_range(0, 7) == 0) ? 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI))
			: CMD_NONE;
	endfunction

	function automatic cfg_t random_timing(input int unsigned reset_max,
			input int unsigned slot_max);
		cfg_t t;
		t.rst_low = 16'($urandom_range(0, reset_max));
		t.rst_rel = 16'($urandom_range(0, reset_max));
		t.pres_wait = 16'($urandom_range(0, reset_max));
		t.rd_low = 16'($urandom_range(0, slot_max));
		t.rd_sample = 16'($urandom_range(0, slot_max));
		t.rd_rec = 16'($urandom_range(0, slot_max));
		t.wr_short = 16'($urandom_range(0, slot_max));
		t.wr_long = 16'($urandom_range(0, slot_max));
		return t;
	endfunction

	// Receiver: runs of ready with short and occasional long stalls between them.
	initial begin
		int unsigned run;
		forever begin
			run = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 600) : $urandom_range(1, 60);
			m_axis_tready <= 1'b1;
			repeat (run) @(posedge clk);
			m_axis_tready <= 1'b0;
			repeat (gap_len()) @(posedge clk);
		end
	end

	// One tick request; returns at the edge that takes it, with tvalid still high.
	task automatic send_tick(input logic [2:0] cmd, input logic [7:0] data, input logic line);
		int unsigned gap;
		gap = (sender_gaps && $urandom_range(0, 9) == 0) ? gap_len() : 0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0000, line, data, cmd};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Starts a command and keeps the ticks coming until it reports done. With jam set,
	// other commands are thrown at the master while it is surely still busy.
	task automatic run_command(input logic [2:0] cmd, input logic [7:0] data, input bit jam);
		int unsigned done_mark;
		int unsigned after;
		logic [2:0]  code;
		done_mark = done_count;
		send_tick(cmd, data, 1'($urandom));
		after = 0;
		while (done_count == done_mark) begin
			after++;
			if (jam && after <= BUSY_SAFE_TICKS && $urandom_range(0, 2) == 0)
				code = 3'($urandom_range(CMD_RESET, CMD_SPARE_HI));
			else
				code = idle_code();
			send_tick(code, 8'($urandom), 1'($urandom));
		end
	endtask

	// Stop sending and wait until every tick has its result.
	task automatic wait_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_beat(input logic [2:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Writes all eight timing registers back to back; the master must be idle.
	task automatic program_timing(input cfg_t t);
		cfg_beat(REG_RST_LOW, t.rst_low);
		cfg_beat(REG_RST_REL, t.rst_rel);
		cfg_beat(REG_PRES_WAIT, t.pres_wait);
		cfg_beat(REG_RD_LOW, t.rd_low);
		cfg_beat(REG_RD_SAMPLE, t.rd_sample);
		cfg_beat(REG_RD_REC, t.rd_rec);
		cfg_beat(REG_WR_SHORT, t.wr_short);
		cfg_beat(REG_WR_LONG, t.wr_long);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default timing: idle ticks with every unknown code leave the master at rest.
		send_tick(CMD_NONE, 8'hFF, 1'b1);
		send_tick(CMD_SPARE_LO, 8'h00, 1'b0);
		send_tick(CMD_SPARE_LO + 3'd1, 8'hFF, 1'b1);
		send_tick(CMD_SPARE_HI, 8'h55, 1'b0);
		wait_results();

		// Zero length phases take one tick each.
		program_timing(cfg_t'({8{16'd0}}));
		run_command(CMD_WRITE, 8'hA5, 1'b0);
		run_command(CMD_READ, 8'h00, 1'b1);
		wait_results();

		// Shortest timing: a lone reset with commands thrown in while busy.
		program_timing(cfg_t'({8{16'd1}}));
		run_command(CMD_RESET, 8'h00, 1'b1);
		wait_results();

		// Small random timing: one byte each way.
		program_timing(random_timing(3, 3));
		run_command(CMD_WRITE, 8'($urandom), 1'b1);
		run_command(CMD_READ, 8'h00, 1'b1);
		wait_results();

		// The temperature program with ticks sent back to back.
		program_timing(cfg_t'({8{16'd1}}));
		sender_gaps = 1'b0;
		run_command(CMD_TEMP, 8'h00, 1'b1);
		sender_gaps = 1'b1;
		wait_results();

		if (fail_count == 0 && outstanding == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Hang guard: several times the slowest run with every tick hit by both stalls.
	initial begin
		#5000000;
		$display("FAIL");
		$finish;
	end

endmodule
